// File: hw/rtl/pfde_pkg.sv
package pfde_pkg;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_PIXEL   = 3'd1;
  localparam logic [2:0] OP_HLINE   = 3'd2;
  localparam logic [2:0] OP_VLINE   = 3'd3;
  localparam logic [2:0] OP_RECT    = 3'd4;
  localparam logic [2:0] OP_REFRESH = 3'd5;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [2:0] {
    SEG_PIXEL,
    SEG_HLINE,
    SEG_VLINE,
    SEG_RTOP,
    SEG_RBOT,
    SEG_RLEFT,
    SEG_RRIGHT
  } seg_t;

  typedef enum logic [2:0] {
    OSEL_ACK,
    OSEL_CMD0,
    OSEL_CMD1,
    OSEL_CMD2,
    OSEL_DATA
  } out_sel_t;

  typedef struct packed {
    logic     in_load;
    logic     clr_start;
    logic     clr_step;
    logic     seg_load;
    seg_t     seg;
    logic     pix_rd;
    logic     pix_wr;
    logic     pix_skip;
    logic     ref_start;
    logic     ref_rd;
    logic     ref_acc;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rect_empty;
    logic seg_done;
    logic pix_in;
    logic ref_word_full;
    logic ref_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: hw/rtl/pfde_datapath.sv
module pfde_datapath import pfde_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [7:0]  in_x,
  input  logic [7:0]  in_y,
  input  logic [7:0]  in_length,
  input  logic [7:0]  in_height,
  input  logic [2:0]  in_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [63:0] out_value,
  output logic        out_last
);

  localparam int NUM_PAGES  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_SIZE = PANEL_WIDTH * NUM_PAGES;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam logic [AW-1:0] PW_A     = AW'(PANEL_WIDTH);
  localparam logic [AW-1:0] LAST_A   = AW'(STORE_SIZE - 1);

  logic [7:0]  mem [STORE_SIZE];

  logic [7:0]  x_r, y_r, len_r, ht_r;
  logic [2:0]  page_r;
  logic [AW-1:0] clr_addr_r;
  logic [8:0]  cur_col_r, cur_row_r;
  logic [7:0]  cnt_r;
  logic        horiz_r;
  logic [7:0]  ref_col_r;
  logic        rvalid_r;
  logic [7:0]  rdata_r;
  logic [63:0] word_r;
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [63:0] out_value_r;
  logic        out_last_r;

  logic [AW-1:0] pix_addr, ref_addr, rd_addr;
  logic [7:0]    pix_mask;
  logic          out_free;
  logic [63:0]   val_sel;
  logic [1:0]    kind_sel;

  assign pix_addr = AW'(cur_row_r[6:3]) * PW_A + AW'(cur_col_r[7:0]);
  assign ref_addr = AW'(page_r) * PW_A + AW'(ref_col_r[6:0]);
  assign rd_addr  = cmd.pix_rd ? pix_addr : ref_addr;
  assign pix_mask = 8'(1) << cur_row_r[2:0];
  assign out_free = !out_valid_r || !out_stall;

  assign sts.clr_last      = (clr_addr_r == LAST_A);
  assign sts.rect_empty    = (len_r == 8'd0) || (ht_r == 8'd0);
  assign sts.seg_done      = (cnt_r == 8'd0);
  assign sts.pix_in        = (cur_col_r < 9'(PANEL_WIDTH)) && (cur_row_r < 9'(PANEL_HEIGHT));
  assign sts.ref_word_full = (ref_col_r[2:0] == 3'd0);
  assign sts.ref_done      = ref_col_r[7];
  assign sts.out_free      = out_free;

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr_r] <= 8'h00;
    end else if (cmd.pix_wr) begin
      mem[pix_addr] <= rdata_r | pix_mask;
    end
    if (cmd.pix_rd || cmd.ref_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_start) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      x_r    <= in_x;
      y_r    <= in_y;
      len_r  <= in_length;
      ht_r   <= in_height;
      page_r <= in_page;
    end
    if (cmd.seg_load) begin
      unique case (cmd.seg)
        SEG_PIXEL: begin
          cur_col_r <= {1'b0, x_r};
          cur_row_r <= {1'b0, y_r};
          cnt_r     <= 8'd1;
          horiz_r   <= 1'b1;
        end
        SEG_HLINE, SEG_RTOP: begin
          cur_col_r <= {1'b0, x_r};
          cur_row_r <= {1'b0, y_r};
          cnt_r     <= len_r;
          horiz_r   <= 1'b1;
        end
        SEG_RBOT: begin
          cur_col_r <= {1'b0, x_r};
          cur_row_r <= {1'b0, y_r} + {1'b0, ht_r} - 9'd1;
          cnt_r     <= len_r;
          horiz_r   <= 1'b1;
        end
        SEG_VLINE: begin
          cur_col_r <= {1'b0, x_r};
          cur_row_r <= {1'b0, y_r};
          cnt_r     <= len_r;
          horiz_r   <= 1'b0;
        end
        SEG_RLEFT: begin
          cur_col_r <= {1'b0, x_r};
          cur_row_r <= {1'b0, y_r};
          cnt_r     <= ht_r;
          horiz_r   <= 1'b0;
        end
        SEG_RRIGHT: begin
          cur_col_r <= {1'b0, x_r} + {1'b0, len_r} - 9'd1;
          cur_row_r <= {1'b0, y_r};
          cnt_r     <= ht_r;
          horiz_r   <= 1'b0;
        end
        default: begin
          cnt_r <= 8'd0;
        end
      endcase
    end else if (cmd.pix_wr || cmd.pix_skip) begin
      cnt_r <= cnt_r - 8'd1;
      if (horiz_r) begin
        cur_col_r <= cur_col_r + 9'd1;
      end else begin
        cur_row_r <= cur_row_r + 9'd1;
      end
    end
    if (cmd.ref_start) begin
      ref_col_r <= 8'd0;
    end else if (cmd.ref_rd) begin
      ref_col_r <= ref_col_r + 8'd1;
      rvalid_r  <= (32'(page_r) < NUM_PAGES) && (32'(ref_col_r) < PANEL_WIDTH);
    end
    if (cmd.ref_acc) begin
      word_r <= {(rvalid_r ? rdata_r : 8'h00), word_r[63:8]};
    end
  end

  always_comb begin
    unique case (cmd.out_sel)
      OSEL_ACK: begin
        kind_sel = KIND_ACK;
        val_sel  = 64'd0;
      end
      OSEL_CMD0: begin
        kind_sel = KIND_CMD;
        val_sel  = {56'd0, CMD_PAGE_BASE + {5'd0, page_r}};
      end
      OSEL_CMD1: begin
        kind_sel = KIND_CMD;
        val_sel  = {56'd0, CMD_COL_LOW};
      end
      OSEL_CMD2: begin
        kind_sel = KIND_CMD;
        val_sel  = {56'd0, CMD_COL_HIGH};
      end
      OSEL_DATA: begin
        kind_sel = KIND_DATA;
        val_sel  = word_r;
      end
      default: begin
        kind_sel = KIND_ACK;
        val_sel  = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load && out_free) begin
      out_kind_r  <= kind_sel;
      out_value_r <= val_sel;
      out_last_r  <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

// File: hw/rtl/pfde_ctrl.sv
module pfde_ctrl import pfde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_op,
  output logic       in_stall,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_RECT, ST_SEG, ST_PIX, ST_WR, ST_ACK,
    ST_C0, ST_C1, ST_C2, ST_RD, ST_ACC, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  seg_t   seg_r, seg_nxt;
  logic   boot_r, boot_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    seg_nxt   = seg_r;
    boot_nxt  = boot_r;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = boot_r ? ST_IDLE : ST_ACK;
          boot_nxt  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          unique case (in_op)
            OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = ST_CLR;
            end
            OP_PIXEL: begin
              seg_nxt   = SEG_PIXEL;
              state_nxt = ST_SEG;
            end
            OP_HLINE: begin
              seg_nxt   = SEG_HLINE;
              state_nxt = ST_SEG;
            end
            OP_VLINE: begin
              seg_nxt   = SEG_VLINE;
              state_nxt = ST_SEG;
            end
            OP_RECT: begin
              seg_nxt   = SEG_RTOP;
              state_nxt = ST_RECT;
            end
            OP_REFRESH: begin
              cmd.ref_start = 1'b1;
              state_nxt     = ST_C0;
            end
            default: state_nxt = ST_ACK;
          endcase
        end
      end
      ST_RECT: state_nxt = sts.rect_empty ? ST_ACK : ST_SEG;
      ST_SEG: begin
        cmd.seg_load = 1'b1;
        cmd.seg      = seg_r;
        state_nxt    = ST_PIX;
      end
      ST_PIX: begin
        priority if (sts.seg_done) begin
          unique case (seg_r)
            SEG_RTOP: begin
              seg_nxt   = SEG_RBOT;
              state_nxt = ST_SEG;
            end
            SEG_RBOT: begin
              seg_nxt   = SEG_RLEFT;
              state_nxt = ST_SEG;
            end
            SEG_RLEFT: begin
              seg_nxt   = SEG_RRIGHT;
              state_nxt = ST_SEG;
            end
            default: state_nxt = ST_ACK;
          endcase
        end else if (sts.pix_in) begin
          cmd.pix_rd = 1'b1;
          state_nxt  = ST_WR;
        end else begin
          cmd.pix_skip = 1'b1;
        end
      end
      ST_WR: begin
        cmd.pix_wr = 1'b1;
        state_nxt  = ST_PIX;
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_ACK;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_C0: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CMD0;
          state_nxt    = ST_C1;
        end
      end
      ST_C1: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CMD1;
          state_nxt    = ST_C2;
        end
      end
      ST_C2: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_CMD2;
          state_nxt    = ST_RD;
        end
      end
      ST_RD: begin
        cmd.ref_rd = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        cmd.ref_acc = 1'b1;
        state_nxt   = sts.ref_word_full ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_DATA;
          cmd.out_last = sts.ref_done;
          state_nxt    = sts.ref_done ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      seg_r   <= SEG_PIXEL;
      boot_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      boot_r  <= boot_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free) else $error("result loaded into a full output register");
  a_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_wr |-> $past(cmd.pix_rd)) else $error("pixel write without preceding read");
  a_word: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_sel == OSEL_DATA) |-> sts.ref_word_full)
    else $error("data word sent before eight columns gathered");
  a_boot: assert property (@(posedge clk) disable iff (!rst_n)
    (boot_r && state_r == ST_CLR) |-> !cmd.out_load) else $error("result during reset clear");

endmodule

// File: hw/rtl/page_framebuffer_draw_engine_top.sv
// Monochrome page-addressed frame store with a drawing-command front end.
// Input channel (in_valid/in_stall): one command per transfer, carrying op,
// x, y, length, height and page. One command is worked on at a time; in_stall
// is low only while the engine is idle, so the next transfer in is taken only
// after the previous command has loaded its last result.
// Result channel (out_valid/out_stall): a drawing command gives a single
// acknowledge; a page refresh gives three command bytes then 16 data words,
// with out_last on the final one.
// A clear writes zero to every store byte (PANEL_WIDTH times the page count),
// then gives the acknowledge. Each drawn pixel takes a read and a write of
// the store, a clipped pixel is skipped without either, and each line or
// rectangle side has a set-up step. A refresh reads and gathers each column
// byte, and loads a data word after every eighth one.
// After reset the same clearing pass runs through the store, one byte a
// cycle, with in_stall high; no result is produced for it.
// A stalled receiver holds the output register; the engine waits until the
// pending result is transferred before it loads the next.
module page_framebuffer_draw_engine_top import pfde_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_x,
  input  logic [7:0]  in_y,
  input  logic [7:0]  in_length,
  input  logic [7:0]  in_height,
  input  logic [2:0]  in_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [63:0] out_value,
  output logic        out_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  pfde_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  pfde_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_length (in_length),
    .in_height (in_height),
    .in_page   (in_page),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_value (out_value),
    .out_last  (out_last)
  );

endmodule

// File: test/page_framebuffer_draw_engine_checker.sv
module page_framebuffer_draw_engine_checker import pfde_pkg::*; #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_x,
  input  logic [7:0]  in_y,
  input  logic [7:0]  in_length,
  input  logic [7:0]  in_height,
  input  logic [2:0]  in_page,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic [63:0] out_value,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count,
  output int          results_seen
);

  localparam int NUM_PAGES = (PANEL_HEIGHT + 7) / 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] value;
    logic        last;
  } panel_word_t;

  logic [7:0] pixels [NUM_PAGES * PANEL_WIDTH];
  panel_word_t expected_words [$];

  task automatic report(input string what);
    fail_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic void light(input int col, input int row);
    if (col >= PANEL_WIDTH || row >= PANEL_HEIGHT) return;
    pixels[(row / 8) * PANEL_WIDTH + col] |= 8'(1 << (row % 8));
  endfunction

  function automatic void run_across(input int col, input int row, input int len);
    for (int i = 0; i < len && col + i < PANEL_WIDTH; i++) light(col + i, row);
  endfunction

  function automatic void run_down(input int col, input int row, input int len);
    for (int i = 0; i < len && row + i < PANEL_HEIGHT; i++) light(col, row + i);
  endfunction

  function automatic logic [7:0] column_byte(input int pg, input int col);
    if (pg >= NUM_PAGES || col >= PANEL_WIDTH) return 8'h00;
    return pixels[pg * PANEL_WIDTH + col];
  endfunction

  function automatic void draw_command(input logic [2:0] op, input int x, input int y,
                                       input int len, input int ht, input int pg);
    logic [63:0] word;
    case (op)
      OP_CLEAR: foreach (pixels[i]) pixels[i] = 8'h00;
      OP_PIXEL: light(x, y);
      OP_HLINE: run_across(x, y, len);
      OP_VLINE: run_down(x, y, len);
      OP_RECT: begin
        if (len != 0 && ht != 0) begin
          run_across(x, y, len);
          run_across(x, y + ht - 1, len);
          run_down(x, y, ht);
          run_down(x + len - 1, y, ht);
        end
      end
      OP_REFRESH: begin
        expected_words.push_back('{KIND_CMD, 64'(CMD_PAGE_BASE + 8'(pg)), 1'b0});
        expected_words.push_back('{KIND_CMD, 64'(CMD_COL_LOW), 1'b0});
        expected_words.push_back('{KIND_CMD, 64'(CMD_COL_HIGH), 1'b0});
        for (int w = 0; w < 16; w++) begin
          word = '0;
          for (int b = 0; b < 8; b++) word[8*b +: 8] = column_byte(pg, w * 8 + b);
          expected_words.push_back('{KIND_DATA, word, 1'(w == 15)});
        end
        return;
      end
      default: ;
    endcase
    expected_words.push_back('{KIND_ACK, 64'd0, 1'b1});
  endfunction

  panel_word_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (pixels[i]) pixels[i] = 8'h00;
      expected_words.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected result kind %0d value %h", out_kind, out_value));
        end else begin
          want = expected_words.pop_front();
          if (out_kind !== want.kind)
            report($sformatf("kind %0d, wanted %0d", out_kind, want.kind));
          if (out_value !== want.value)
            report($sformatf("value %h, wanted %h", out_value, want.value));
          if (out_last !== want.last)
            report($sformatf("last %b, wanted %b", out_last, want.last));
        end
      end
      // The transfer in is predicted after the output check, so its results queue behind.
      if (in_valid && !in_stall)
        draw_command(in_op, in_x, in_y, in_length, in_height, in_page);
    end
    pending_count = expected_words.size();
  end

endmodule

// File: test/page_framebuffer_draw_engine_top_test.sv
module page_framebuffer_draw_engine_top_test import pfde_pkg::*;;

  localparam int ITEMS = 230;
  localparam int CYCLE_LIMIT = 5000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = '0;
  logic [7:0]  in_x = '0;
  logic [7:0]  in_y = '0;
  logic [7:0]  in_length = '0;
  logic [7:0]  in_height = '0;
  logic [2:0]  in_page = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [1:0]  out_kind;
  logic [63:0] out_value;
  logic        out_last;
  int          fail_count;
  int          pending_count;
  int          results_seen;
  int          cycle_count = 0;
  int          commands_sent = 0;
  int          refreshes_sent = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  page_framebuffer_draw_engine_top dut (.*);

  page_framebuffer_draw_engine_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at cycle limit");
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver stalls in short bursts until the calm part of the run.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b1;
    else if (calm) out_stall <= 1'b0;
    else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  task automatic send(input logic [2:0] op, input logic [7:0] x, input logic [7:0] y,
                      input logic [7:0] len, input logic [7:0] ht, input logic [2:0] pg);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op; in_x <= x; in_y <= y; in_length <= len; in_height <= ht; in_page <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    commands_sent++;
    if (op == OP_REFRESH) refreshes_sent++;
  endtask

  task automatic random_command();
    logic [2:0] op;
    logic [7:0] x, y, len, ht;
    op = 3'($urandom_range(0, 99) < 3 ? OP_CLEAR : $urandom_range(1, 7));
    if (op == OP_CLEAR && $urandom_range(0, 1)) op = OP_PIXEL;
    // Mostly on-panel coordinates and short lengths, with wide values now and then.
    x = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 135));
    y = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 70));
    len = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40));
    ht = $urandom_range(0, 7) == 0 ? 8'($urandom) : 8'($urandom_range(0, 40));
    send(op, x, y, len, ht, 3'($urandom));
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    // Directed part: corners, clipping, zero sizes, unused op codes, all pages.
    send(OP_REFRESH, 0, 0, 0, 0, 3'd0);
    send(OP_PIXEL, 0, 0, 0, 0, 3'd0);
    send(OP_PIXEL, 127, 63, 0, 0, 3'd7);
    send(OP_PIXEL, 128, 64, 0, 0, 3'd0);
    send(OP_PIXEL, 255, 255, 255, 255, 3'd7);
    send(OP_HLINE, 120, 5, 255, 0, 3'd0);
    send(OP_HLINE, 10, 9, 0, 0, 3'd0);
    send(OP_VLINE, 3, 60, 255, 0, 3'd0);
    send(OP_VLINE, 200, 0, 10, 0, 3'd0);
    send(OP_RECT, 20, 20, 0, 9, 3'd0);
    send(OP_RECT, 20, 20, 9, 0, 3'd0);
    send(OP_RECT, 250, 250, 255, 255, 3'd0);
    send(OP_RECT, 100, 40, 255, 255, 3'd0);
    send(OP_RECT, 30, 30, 1, 1, 3'd0);
    send(3'd6, 8'hAA, 8'h55, 8'hAA, 8'h55, 3'd5);
    send(3'd7, 8'h55, 8'hAA, 8'h55, 8'hAA, 3'd2);
    for (int p = 0; p < 8; p++) send(OP_REFRESH, 0, 0, 0, 0, 3'(p));
    send(OP_CLEAR, 0, 0, 0, 0, 3'd0);
    send(OP_REFRESH, 0, 0, 0, 0, 3'd7);
    for (int i = 0; i < ITEMS; i++) begin
      if (i == ITEMS / 2) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
      end
      if (i == ITEMS - 30) calm = 1'b1;
      random_command();
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d commands (%0d page refreshes); checked %0d results.",
             commands_sent, refreshes_sent, results_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
